[design/fil_pkg.sv]
// shared types and constants for the flash image loader checksum block
`default_nettype none
package fil_pkg;

    typedef enum logic [1:0] {
        OP_STATUS   = 2'd0,
        OP_HEADER   = 2'd1,
        OP_DATA     = 2'd2,
        OP_CHECKSUM = 2'd3
    } fil_opcode_t;

    typedef enum logic {
        REG_MAX_IMAGE_BYTES    = 1'b0,
        REG_IMAGE_BASE_ADDRESS = 1'b1
    } fil_reg_index_t;

    localparam logic [31:0] ERASE_KEY           = 32'h666C_6170;
    localparam logic [31:0] WORD_BYTES          = 32'd4;
    localparam logic [31:0] MAX_IMAGE_BYTES_RST = 32'd262144;
    localparam logic [31:0] IMAGE_BASE_RST      = 32'd0;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] payload_low;
        logic [31:0] payload_high;
        logic        last_in_message;
    } fil_in_t;

    typedef struct packed {
        logic        status;
        logic        erase_request;
        logic [31:0] erase_size;
        logic        write_valid;
        logic [31:0] write_address;
        logic [31:0] write_word;
        logic        finish;
        logic        launch;
    } fil_out_t;

    typedef struct packed {
        logic [31:0] max_image_bytes;
        logic [31:0] image_base_address;
    } fil_cfg_t;

endpackage
`default_nettype wire

[design/fil_core.sv]
// image state and command decode for the flash image loader
`default_nettype none
module fil_core (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             step,
    input  wire fil_pkg::fil_in_t  cmd,
    input  wire fil_pkg::fil_cfg_t cfg,
    output fil_pkg::fil_out_t      result
);
    import fil_pkg::*;

    logic [31:0] image_size_reg, image_size_next;
    logic [31:0] running_sum_reg, running_sum_next;
    logic [31:0] byte_count_reg, byte_count_next;
    logic        image_complete_reg, image_complete_next;
    logic [32:0] count_inc;
    logic [31:0] count_sat;

    // saturating pointer advance, carry out means past the top
    assign count_inc = {1'b0, byte_count_reg} + {1'b0, WORD_BYTES};
    assign count_sat = count_inc[32] ? 32'hFFFF_FFFF : count_inc[31:0];

    always_comb
    begin
        image_size_next     = image_size_reg;
        running_sum_next    = running_sum_reg;
        byte_count_next     = byte_count_reg;
        image_complete_next = image_complete_reg;
        result              = '0;
        case (fil_opcode_t'(cmd.opcode))
            OP_STATUS:
            begin
                result.status = 1'b0;
            end
            OP_HEADER:
            begin
                if (cmd.payload_high != ERASE_KEY
                    || cmd.payload_low > cfg.max_image_bytes)
                begin
                    result.status = 1'b1;
                end
                else
                begin
                    image_size_next      = cmd.payload_low;
                    running_sum_next     = '0;
                    byte_count_next      = '0;
                    image_complete_next  = 1'b0;
                    result.erase_request = 1'b1;
                    result.erase_size    = cmd.payload_low;
                end
            end
            OP_DATA:
            begin
                if (image_size_reg == '0)
                begin
                    result.status = 1'b1;
                end
                else
                begin
                    result.write_valid   = 1'b1;
                    result.write_address = cfg.image_base_address + byte_count_reg;
                    result.write_word    = cmd.payload_low;
                    running_sum_next     = running_sum_reg + cmd.payload_low;
                    byte_count_next      = count_sat;
                    if (cmd.last_in_message && count_sat >= image_size_reg)
                    begin
                        image_complete_next = 1'b1;
                        result.finish       = 1'b1;
                    end
                end
            end
            OP_CHECKSUM:
            begin
                if (image_complete_reg && cmd.payload_low == running_sum_reg)
                begin
                    result.launch = 1'b1;
                end
                else
                begin
                    result.status = 1'b1;
                end
            end
            default:
            begin
                result.status = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_size_reg     <= '0;
            running_sum_reg    <= '0;
            byte_count_reg     <= '0;
            image_complete_reg <= 1'b0;
        end
        else if (step)
        begin
            image_size_reg     <= image_size_next;
            running_sum_reg    <= running_sum_next;
            byte_count_reg     <= byte_count_next;
            image_complete_reg <= image_complete_next;
        end
    end

    a_erase_clears_count: assert property (@(posedge clk) disable iff (!rst_n)
        step && result.erase_request |=> byte_count_reg == '0 && !image_complete_reg)
        else $error("accepted header did not restart the image");

    a_error_no_action: assert property (@(posedge clk) disable iff (!rst_n)
        result.status |-> !result.erase_request && !result.write_valid
                          && !result.finish && !result.launch)
        else $error("error result carries an action");

    a_write_needs_size: assert property (@(posedge clk) disable iff (!rst_n)
        result.write_valid |-> image_size_reg != '0)
        else $error("write issued with no image size");

    a_launch_needs_complete: assert property (@(posedge clk) disable iff (!rst_n)
        result.launch |-> image_complete_reg)
        else $error("launch on an incomplete image");

endmodule
`default_nettype wire

[design/flash_image_loader_checksum.sv]
// top level of the flash image loader checksum block
// a word held in in_data_reg has its result registered in out_data_reg, which drives out_data
// throughput: one word per cycle while out_stall is low, set by the state update in fil_core
// while a result waits on out_stall an empty input register takes one word, then in_stall rises
// reset clears the pipeline valids, the image state and sets max_image_bytes to 262144
// and image_base_address to 0
`default_nettype none
module flash_image_loader_checksum (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire fil_pkg::fil_in_t  in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output fil_pkg::fil_out_t      out_data,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [31:0]       cfg_data
);
    import fil_pkg::*;

    logic     in_valid_reg;
    fil_in_t  in_data_reg;
    logic     out_valid_reg;
    fil_out_t out_data_reg;
    fil_cfg_t cfg_reg;
    fil_out_t result;
    logic     out_free;
    logic     step;

    assign out_free  = !out_valid_reg || !out_stall;
    assign step      = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg               <= 1'b0;
            out_valid_reg              <= 1'b0;
            cfg_reg.max_image_bytes    <= MAX_IMAGE_BYTES_RST;
            cfg_reg.image_base_address <= IMAGE_BASE_RST;
        end
        else
        begin
            if (!in_stall)
            begin
                in_valid_reg <= in_valid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (fil_reg_index_t'(cfg_index))
                    REG_MAX_IMAGE_BYTES:    cfg_reg.max_image_bytes    <= cfg_data;
                    REG_IMAGE_BASE_ADDRESS: cfg_reg.image_base_address <= cfg_data;
                    default:                cfg_reg.max_image_bytes    <= cfg_data;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
        if (step)
        begin
            out_data_reg <= result;
        end
    end

    fil_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .cmd    (in_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule
`default_nettype wire
